/* design/sse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sse_pkg;

    localparam int MAX_KEYS  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CNT_W     = $clog2(MAX_KEYS + 1);

    typedef logic [IDX_W-1:0]            idx_t;
    typedef logic [CNT_W-1:0]            cnt_t;
    typedef logic signed [KEY_WIDTH-1:0] key_t;

    // write data source
    typedef enum logic [1:0] {
        WR_KEY,
        WR_CMP,
        WR_CARRY
    } wr_src_t;

    typedef struct packed {
        logic    wr_en;
        idx_t    wr_addr;
        wr_src_t wr_src;
        idx_t    rd_addr;
        logic    carry_ld;
        logic    cmp_step;
        logic    dir_back;
        logic    out_ld;
        logic    out_last;
        logic    out_ovf;
    } dp_cmd_t;

    typedef struct packed {
        logic swap;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* design/sse_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module sse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/sse_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module sse_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sse_pkg::dp_cmd_t    cmd,
    output sse_pkg::dp_status_t      status,
    input  wire sse_pkg::key_t       key_in,
    output sse_pkg::key_t            key_out,
    output logic                     last_out,
    output logic                     overflow,
    output logic                     out_valid,
    input  wire logic                out_stall
);

    sse_pkg::key_t rd_key;
    sse_pkg::key_t wr_key;
    sse_pkg::key_t carry_reg;
    sse_pkg::key_t carry_next;
    sse_pkg::key_t key_out_reg;
    logic          last_out_reg;
    logic          ovf_out_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          swap;

    sse_ram #(
        .WIDTH (sse_pkg::KEY_WIDTH),
        .DEPTH (sse_pkg::MAX_KEYS)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (cmd.wr_addr),
        .wr_data (wr_key),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_key)
    );

    // forward pass carries the running max rightward, backward the min leftward
    assign swap = cmd.dir_back ? (rd_key > carry_reg) : (carry_reg > rd_key);

    always_comb
    begin
        case (cmd.wr_src)
            sse_pkg::WR_KEY:   wr_key = key_in;
            sse_pkg::WR_CMP:   wr_key = swap ? rd_key : carry_reg;
            sse_pkg::WR_CARRY: wr_key = carry_reg;
            default:           wr_key = carry_reg;
        endcase
    end

    always_comb
    begin
        carry_next = carry_reg;
        if (cmd.carry_ld || (cmd.cmp_step && !swap))
        begin
            carry_next = rd_key;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_ld)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        if (cmd.out_ld)
        begin
            key_out_reg  <= rd_key;
            last_out_reg <= cmd.out_last;
            ovf_out_reg  <= cmd.out_ovf;
        end
    end

    assign status.swap     = swap;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign key_out   = key_out_reg;
    assign last_out  = last_out_reg;
    assign overflow  = ovf_out_reg;
    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_ld |-> !out_valid_reg)
        else $error("output beat overwritten before taken");
`endif

endmodule

`default_nettype wire

/* design/sse_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module sse_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                last_in,
    output logic                     in_stall,
    output sse_pkg::dp_cmd_t         cmd,
    input  wire sse_pkg::dp_status_t status
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_F_RD0,
        S_F_LD,
        S_F_RD,
        S_F_CMP,
        S_F_WB,
        S_B_RD0,
        S_B_LD,
        S_B_RD,
        S_B_CMP,
        S_B_WB,
        S_O_RD,
        S_O_LD
    } state_t;

    state_t        state_reg, state_next;
    sse_pkg::cnt_t count_reg, count_next;
    logic          ovf_reg, ovf_next;
    sse_pkg::idx_t left_reg, left_next;
    sse_pkg::idx_t right_reg, right_next;
    sse_pkg::idx_t swap_pos_reg, swap_pos_next;
    sse_pkg::idx_t j_reg, j_next;
    sse_pkg::cnt_t set_size;
    sse_pkg::idx_t last_idx;
    sse_pkg::idx_t j_inc;
    sse_pkg::idx_t j_dec;
    logic          store_full;

    assign store_full = (count_reg == sse_pkg::cnt_t'(sse_pkg::MAX_KEYS));
    assign set_size   = store_full ? count_reg : count_reg + sse_pkg::cnt_t'(1);
    assign last_idx   = sse_pkg::IDX_W'(count_reg - sse_pkg::cnt_t'(1));
    assign j_inc      = j_reg + sse_pkg::idx_t'(1);
    assign j_dec      = j_reg - sse_pkg::idx_t'(1);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        swap_pos_next = swap_pos_reg;
        j_next        = j_reg;
        cmd           = '0;
        cmd.wr_src    = sse_pkg::WR_KEY;
        in_stall      = 1'b1;

        unique case (state_reg)
            S_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (!store_full)
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_addr = sse_pkg::IDX_W'(count_reg);
                        count_next  = count_reg + sse_pkg::cnt_t'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_in)
                    begin
                        j_next = '0;
                        if (set_size >= sse_pkg::cnt_t'(2))
                        begin
                            left_next     = '0;
                            right_next    = sse_pkg::IDX_W'(set_size - sse_pkg::cnt_t'(1));
                            swap_pos_next = sse_pkg::IDX_W'(set_size - sse_pkg::cnt_t'(1));
                            state_next    = S_F_RD0;
                        end
                        else
                        begin
                            state_next = S_O_RD;
                        end
                    end
                end
            end
            S_F_RD0:
            begin
                cmd.rd_addr = left_reg;
                j_next      = left_reg;
                state_next  = S_F_LD;
            end
            S_F_LD:
            begin
                cmd.carry_ld = 1'b1;
                state_next   = S_F_RD;
            end
            S_F_RD:
            begin
                cmd.rd_addr = j_inc;
                state_next  = S_F_CMP;
            end
            S_F_CMP:
            begin
                cmd.cmp_step = 1'b1;
                cmd.wr_en    = 1'b1;
                cmd.wr_addr  = j_reg;
                cmd.wr_src   = sse_pkg::WR_CMP;
                if (status.swap)
                begin
                    swap_pos_next = j_reg;
                end
                j_next     = j_inc;
                state_next = (j_inc < right_reg) ? S_F_RD : S_F_WB;
            end
            S_F_WB:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = right_reg;
                cmd.wr_src  = sse_pkg::WR_CARRY;
                right_next  = swap_pos_reg;
                if (swap_pos_reg > left_reg)
                begin
                    state_next = S_B_RD0;
                end
                else
                begin
                    j_next     = '0;
                    state_next = S_O_RD;
                end
            end
            S_B_RD0:
            begin
                cmd.rd_addr = right_reg;
                j_next      = right_reg;
                state_next  = S_B_LD;
            end
            S_B_LD:
            begin
                cmd.carry_ld = 1'b1;
                state_next   = S_B_RD;
            end
            S_B_RD:
            begin
                cmd.rd_addr = j_dec;
                state_next  = S_B_CMP;
            end
            S_B_CMP:
            begin
                cmd.cmp_step = 1'b1;
                cmd.dir_back = 1'b1;
                cmd.wr_en    = 1'b1;
                cmd.wr_addr  = j_reg;
                cmd.wr_src   = sse_pkg::WR_CMP;
                if (status.swap)
                begin
                    swap_pos_next = j_reg;
                end
                j_next     = j_dec;
                state_next = (j_dec > left_reg) ? S_B_RD : S_B_WB;
            end
            S_B_WB:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = left_reg;
                cmd.wr_src  = sse_pkg::WR_CARRY;
                left_next   = swap_pos_reg;
                if (swap_pos_reg < right_reg)
                begin
                    state_next = S_F_RD0;
                end
                else
                begin
                    j_next     = '0;
                    state_next = S_O_RD;
                end
            end
            S_O_RD:
            begin
                cmd.rd_addr = j_reg;
                if (status.out_free)
                begin
                    state_next = S_O_LD;
                end
            end
            S_O_LD:
            begin
                cmd.out_ld   = 1'b1;
                cmd.out_last = (j_reg == last_idx);
                cmd.out_ovf  = ovf_reg;
                if (j_reg == last_idx)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = S_LOAD;
                end
                else
                begin
                    j_next     = j_inc;
                    state_next = S_O_RD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            left_reg     <= '0;
            right_reg    <= '0;
            swap_pos_reg <= '0;
            j_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            left_reg     <= left_next;
            right_reg    <= right_next;
            swap_pos_reg <= swap_pos_next;
            j_reg        <= j_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sse_pkg::cnt_t'(sse_pkg::MAX_KEYS))
        else $error("key count beyond store depth");

    a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD && state_reg != S_O_RD && state_reg != S_O_LD)
            |-> left_reg <= right_reg)
        else $error("sort bounds crossed");

    a_sort_write_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && state_reg != S_LOAD)
            |-> sse_pkg::cnt_t'(cmd.wr_addr) < count_reg)
        else $error("sort wrote outside the stored set");

    a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_ld && cmd.out_last) |=> (count_reg == '0 && !ovf_reg))
        else $error("set not cleared after final beat");
`endif

endmodule

`default_nettype wire

/* design/shaker_sort_engine_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sorts a set of signed keys ascending. While loading, keys stream in one per
// cycle; the beat with last_in set closes the set (up to MAX_KEYS keys are
// kept, extras are dropped and flag overflow on every output beat of that
// set). The set is then sorted in place in the key store by cocktail shaker
// passes: each compare-exchange is a store read, then a compare and write
// back, and each pass adds setup and a final write-back; the registered store
// read is what every compare waits on. The sorted keys then leave one beat at
// a time, each read from the store and then loaded into the output register,
// last_out on the greatest.
// Input is stalled from the closing beat until the last sorted beat is loaded
// into the output register.

module shaker_sort_engine_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire sse_pkg::key_t key_in,
    input  wire logic          last_in,
    output logic               out_valid,
    input  wire logic          out_stall,
    output sse_pkg::key_t      key_out,
    output logic               last_out,
    output logic               overflow
);

    sse_pkg::dp_cmd_t    cmd;
    sse_pkg::dp_status_t status;

    sse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last_in  (last_in),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    sse_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .key_in    (key_in),
        .key_out   (key_out),
        .last_out  (last_out),
        .overflow  (overflow),
        .out_valid (out_valid),
        .out_stall (out_stall)
    );

endmodule

`default_nettype wire

/* dv/shaker_sort_engine_top_test.sv */
`timescale 1ns / 1ps

module shaker_sort_engine_top_test;

    localparam int            QUIET_LIMIT = 20000;
    localparam sse_pkg::key_t KEY_MIN     = {1'b1, {(sse_pkg::KEY_WIDTH-1){1'b0}}};
    localparam sse_pkg::key_t KEY_MAX     = ~KEY_MIN;

    typedef struct {
        sse_pkg::key_t key;
        logic          last;
        logic          ovf;
    } sorted_beat_t;

    class sort_scoreboard;
        sse_pkg::key_t set_keys[$];
        bit            dropped;
        sorted_beat_t  sorted_q[$];
        int            errors;

        function void log_error(string msg);
            errors++;
            if (errors <= 10)
                $display("ERROR: %s", msg);
        endfunction

        // Collects the keys of the open set; the closing beat sorts them and
        // queues one output beat per stored key.
        function void note_key(sse_pkg::key_t k, bit last);
            sse_pkg::key_t tmp;
            int            j;
            sorted_beat_t  b;
            if (set_keys.size() < sse_pkg::MAX_KEYS)
                set_keys.push_back(k);
            else
                dropped = 1'b1;
            if (!last)
                return;
            for (int i = 1; i < set_keys.size(); i++)
            begin
                tmp = set_keys[i];
                j = i - 1;
                while (j >= 0 && set_keys[j] > tmp)
                begin
                    set_keys[j+1] = set_keys[j];
                    j--;
                end
                set_keys[j+1] = tmp;
            end
            foreach (set_keys[i])
            begin
                b.key  = set_keys[i];
                b.last = (i == set_keys.size() - 1);
                b.ovf  = dropped;
                sorted_q.push_back(b);
            end
            set_keys.delete();
            dropped = 1'b0;
        endfunction

        function void check_beat(sse_pkg::key_t k, logic l, logic o);
            sorted_beat_t exp_b;
            if (sorted_q.size() == 0)
            begin
                log_error($sformatf("unexpected beat key=%0d last=%b ovf=%b", k, l, o));
                return;
            end
            exp_b = sorted_q.pop_front();
            if (k !== exp_b.key || l !== exp_b.last || o !== exp_b.ovf)
                log_error($sformatf("expected key=%0d last=%b ovf=%b, got key=%0d last=%b ovf=%b",
                                    exp_b.key, exp_b.last, exp_b.ovf, k, l, o));
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    sse_pkg::key_t key_in;
    logic          last_in;
    logic          out_valid;
    logic          out_stall;
    sse_pkg::key_t key_out;
    logic          last_out;
    logic          overflow;

    sort_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int quiet_cycles;
    int items_sent;

    shaker_sort_engine_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .key_in    (key_in),
        .last_in   (last_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .key_out   (key_out),
        .last_out  (last_out),
        .overflow  (overflow)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // output side: check accepted beats, then pick next cycle's stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_beat(key_out, last_out, overflow);
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic offer_key(sse_pkg::key_t k, bit l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        key_in   <= k;
        last_in  <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_key(k, l);
        items_sent++;
    endtask

    task automatic send_set(sse_pkg::key_t ks[$]);
        foreach (ks[i])
            offer_key(ks[i], i == ks.size() - 1);
    endtask

    task automatic send_random_set(int n);
        sse_pkg::key_t ks[$];
        int            style;
        sse_pkg::key_t base;
        style = $urandom_range(4);
        base  = $urandom;
        for (int i = 0; i < n; i++)
        begin
            case (style)
                0: ks.push_back($urandom);
                1: ks.push_back(sse_pkg::key_t'(int'($urandom_range(15)) - 8));  // many duplicates
                2: ks.push_back(base + sse_pkg::key_t'(i * 3));
                3: ks.push_back(base - sse_pkg::key_t'(i * 3));
                default:
                    case ($urandom_range(3))
                        0: ks.push_back(KEY_MIN);
                        1: ks.push_back(KEY_MAX);
                        2: ks.push_back('0);
                        default: ks.push_back('1);
                    endcase
            endcase
        end
        send_set(ks);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.sorted_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int s_idle, int r_stall, int n_items, int big_n, int hold);
        int start;
        send_idle_pct  = s_idle;
        recv_stall_pct = r_stall;
        hold_left      = hold;
        start          = items_sent;
        while (items_sent - start < n_items)
            send_random_set($urandom_range(1, 10));
        if (big_n > 0)
            send_random_set(big_n);
        drain_results();
    endtask

    initial
    begin
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        items_sent     = 0;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        key_in         <= '0;
        last_in        <= 1'b0;
        out_stall      <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-key sets at both extremes, then small shaped sets
        send_set('{KEY_MAX});
        send_set('{KEY_MIN});
        send_set('{KEY_MAX, KEY_MIN});
        send_set('{0, -1, 1, 0});
        send_set('{5, 4, 3, 2, 1});
        send_set('{1, 2, 3});
        send_set('{KEY_MIN, KEY_MAX, KEY_MIN, KEY_MAX});
        drain_results();

        // long output hold first, so the block backs up onto its input
        run_phase(0, 0, 15, 0, 400);
        run_phase(70, 0, 15, 0, 0);
        run_phase(0, 70, 10, sse_pkg::MAX_KEYS + 1, 0);  // closing key dropped
        run_phase(14, 14, 15, 0, 0);

        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.sorted_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
